### src/ide_trf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ide_trf_pkg
// Constants, types and lookup functions of the IDE timing register file.
// ----------------------------------------------------------------------------
package ide_trf_pkg;

  // Register store depth (64..256) and the address width that follows from it
  localparam int REG_COUNT = 256;
  localparam int ADDR_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam int IDX_W = 8;
  localparam int IO_W  = 16;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Decoded I/O ports
  localparam logic [IO_W-1:0] PORT_UNLOCK = 16'h00F4;
  localparam logic [IO_W-1:0] PORT_INDEX  = 16'h00F8;
  localparam logic [IO_W-1:0] PORT_DATA   = 16'h00FC;

  localparam logic [7:0] UNLOCK_KEY = 8'h30;
  localparam logic [7:0] UNMAPPED   = 8'hFF;

  // Registers that feed the channel enables
  localparam logic [IDX_W-1:0] IDX_PORT_EN = 8'h01;
  localparam logic [IDX_W-1:0] IDX_SEC_CTL = 8'h35;
  localparam int PRI_EN_BIT  = 0;
  localparam int SEC_DIS_BIT = 6;

  typedef struct packed {
    logic       ok;
    logic [7:0] mask;
  } wmask_t;

  function automatic wmask_t write_mask(input logic [IDX_W-1:0] idx);
    wmask_t m;
    m.ok   = 1'b1;
    m.mask = 8'h00;
    case (idx) inside
      8'h01:                      m.mask = 8'h8F;
      [8'h02:8'h06], [8'h25:8'h33]: m.mask = 8'h1F;
      8'h07:                      m.mask = 8'hFF;
      8'h09:                      m.mask = 8'hC3;
      8'h0A:                      m.mask = 8'h4F;
      8'h0B, 8'h0D, 8'h0F, 8'h11: m.mask = 8'h03;
      8'h0C, 8'h0E, 8'h10, 8'h12: m.mask = 8'h1F;
      8'h35:                      m.mask = 8'hFF;
      default:                    m.ok   = 1'b0;
    endcase
    return m;
  endfunction

  // Value an entry holds from reset until its first write
  function automatic logic [7:0] reset_value(input logic [IDX_W-1:0] idx);
    logic [7:0] v;
    case (idx)
      8'h00:   v = 8'h57;
      8'h01:   v = 8'h02;
      8'h08:   v = 8'hFF;
      8'h09:   v = 8'h41;
      8'h0C:   v = 8'h02;
      8'h0E:   v = 8'h02;
      8'h10:   v = 8'h02;
      8'h12:   v = 8'h02;
      8'h34:   v = 8'hFF;
      8'h35:   v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### src/ide_timing_config_register_file_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ide_timing_config_register_file_core
// Indexed configuration register file with unlock, index and data ports.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | role
//  --------+------------------------------------------+-----+----------------
//  in      | in_valid/in_ready cmd io_address         | in  | one bus access
//          | write_data                               |     |
//  out     | out_valid/out_ready read_data            | out | access result
//          | primary_enable secondary_enable          |     |
//
//  One item per cycle while the output is not stalled; after accept the result
//  passes the synchronous register-store read, then the output register.
//  Writes land in the store at the accept edge, so the next item sees them.
//  Per-entry valid bits stand in for the reset defaults; no clearing pass.
//  A stalled output holds the pipe; in_ready drops only when both stages fill.
// ----------------------------------------------------------------------------
module ide_timing_config_register_file_core
  import ide_trf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd,
  input  wire logic [IO_W-1:0]   io_address,
  input  wire logic [7:0]        write_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             read_data,
  output logic                   primary_enable,
  output logic                   secondary_enable
);

  // architectural state
  logic [7:0]           unlock_byte;
  logic [IDX_W-1:0]     selected_index;
  logic [REG_COUNT-1:0] vld;
  logic                 pri_bit;
  logic                 sec_dis;

  logic [7:0] mem [REG_COUNT];
  logic [7:0] mem_q;

  // read stage
  logic             s1_valid;
  logic             s1_from_mem;
  logic             s1_vld;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_rd;
  logic             s1_pri;
  logic             s1_sec;

  logic             acc;
  logic             s1_adv;
  logic             is_wr;
  logic             in_range;
  wmask_t           wm;
  logic             data_wr;
  logic [7:0]       wbyte;
  logic [ADDR_W-1:0] addr;
  logic             pri_bit_next;
  logic             sec_dis_next;
  logic [7:0]       rd_fixed;
  logic [7:0]       s1_data;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign acc      = in_valid && in_ready;

  assign is_wr    = (cmd == CMD_WRITE);
  assign in_range = ({1'b0, selected_index} < (IDX_W + 1)'(REG_COUNT));
  assign addr     = selected_index[ADDR_W-1:0];
  assign wm       = write_mask(selected_index);
  assign wbyte    = write_data & wm.mask;
  assign data_wr  = acc && is_wr && (io_address == PORT_DATA)
                    && (unlock_byte == UNLOCK_KEY) && wm.ok && in_range;

  always_comb begin
    pri_bit_next = pri_bit;
    sec_dis_next = sec_dis;
    if (data_wr && selected_index == IDX_PORT_EN) begin
      pri_bit_next = wbyte[PRI_EN_BIT];
    end
    if (data_wr && selected_index == IDX_SEC_CTL) begin
      sec_dis_next = wbyte[SEC_DIS_BIT];
    end
  end

  // byte returned when the store is not involved
  always_comb begin
    if (is_wr) begin
      rd_fixed = 8'h00;
    end else if (io_address == PORT_UNLOCK) begin
      rd_fixed = unlock_byte;
    end else if (io_address == PORT_DATA) begin
      rd_fixed = 8'h00;  // index beyond the store
    end else begin
      rd_fixed = UNMAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_byte    <= 8'h00;
      selected_index <= '0;
      vld            <= '0;
      pri_bit        <= 1'b0;
      sec_dis        <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (acc && is_wr && io_address == PORT_UNLOCK) begin
        unlock_byte <= write_data;
      end
      if (acc && is_wr && io_address == PORT_INDEX) begin
        selected_index <= write_data;
      end
      if (data_wr) begin
        vld[addr] <= 1'b1;
      end
      pri_bit <= pri_bit_next;
      sec_dis <= sec_dis_next;
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // register store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (data_wr) begin
      mem[addr] <= wbyte;
    end
    if (acc) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_from_mem <= !is_wr && (io_address == PORT_DATA) && in_range;
      s1_vld      <= vld[addr];
      s1_idx      <= selected_index;
      s1_rd       <= rd_fixed;
      s1_pri      <= pri_bit_next;
      s1_sec      <= pri_bit_next && !sec_dis_next;
    end
  end

  assign s1_data = s1_vld ? mem_q : reset_value(s1_idx);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data        <= s1_from_mem ? s1_data : s1_rd;
      primary_enable   <= s1_pri;
      secondary_enable <= s1_sec;
    end
  end

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IDE timing configuration register file.
// Bus accesses go in through the valid/ready input channel, in bursts with
// random gaps. A scoreboard keeps its own copy of the unlock byte, the index
// and the register store, predicts each result and compares it field by
// field. Directed accesses cover the ports, locking, masks and read-only
// indices; random sequences select an index, at times unlock, and access the data
// port, mixed with unmapped and near-miss addresses.
// ----------------------------------------------------------------------------
import ide_trf_pkg::*;

typedef struct packed {
  logic [7:0] rd;
  logic       pri;
  logic       sec;
} access_result_t;

class ide_reg_scoreboard;
  logic [7:0]     unlock_q;
  logic [7:0]     index_q;
  logic [7:0]     regs [REG_COUNT];
  access_result_t expected_q [$];
  int             mismatches;

  function new();
    for (int i = 0; i < REG_COUNT; i++) regs[i] = 8'h00;
    unlock_q   = 8'h00;
    index_q    = 8'h00;
    mismatches = 0;
    // power-on defaults
    regs[8'h00] = 8'h57;
    regs[8'h01] = 8'h02;
    regs[8'h08] = 8'hFF;
    regs[8'h09] = 8'h41;
    regs[8'h0C] = 8'h02;
    regs[8'h0E] = 8'h02;
    regs[8'h10] = 8'h02;
    regs[8'h12] = 8'h02;
    regs[8'h34] = 8'hFF;
    regs[8'h35] = 8'h01;
  endfunction

  // -1 marks an index that drops writes
  function int mask_of(logic [7:0] idx);
    if (idx == 8'h01) return 'h8F;
    if (idx >= 8'h02 && idx <= 8'h06) return 'h1F;
    if (idx >= 8'h25 && idx <= 8'h33) return 'h1F;
    if (idx == 8'h07 || idx == 8'h35) return 'hFF;
    if (idx == 8'h09) return 'hC3;
    if (idx == 8'h0A) return 'h4F;
    if (idx == 8'h0B || idx == 8'h0D || idx == 8'h0F || idx == 8'h11) return 'h03;
    if (idx == 8'h0C || idx == 8'h0E || idx == 8'h10 || idx == 8'h12) return 'h1F;
    return -1;
  endfunction

  function logic [7:0] reg_rd(logic [7:0] idx);
    if (int'(idx) < REG_COUNT) return regs[idx];
    return 8'h00;
  endfunction

  function void note_access(logic c, logic [IO_W-1:0] a, logic [7:0] d);
    access_result_t r;
    int             m;
    logic [7:0]     port_en;
    logic [7:0]     sec_ctl;
    r.rd = 8'h00;
    if (c == CMD_WRITE) begin
      if (a == PORT_UNLOCK) begin
        unlock_q = d;
      end else if (a == PORT_INDEX) begin
        index_q = d;
      end else if (a == PORT_DATA && unlock_q == UNLOCK_KEY) begin
        m = mask_of(index_q);
        if (m >= 0 && int'(index_q) < REG_COUNT) regs[index_q] = d & m[7:0];
      end
    end else begin
      if (a == PORT_UNLOCK) r.rd = unlock_q;
      else if (a == PORT_DATA) r.rd = reg_rd(index_q);
      else r.rd = UNMAPPED;
    end
    port_en = reg_rd(IDX_PORT_EN);
    sec_ctl = reg_rd(IDX_SEC_CTL);
    r.pri = port_en[PRI_EN_BIT];
    r.sec = r.pri && !sec_ctl[SEC_DIS_BIT];
    expected_q.push_back(r);
  endfunction

  function void check_access(logic [7:0] rd, logic pri, logic sec);
    access_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result rd=%02h pri=%b sec=%b", $realtime, rd, pri, sec);
      return;
    end
    e = expected_q.pop_front();
    if (e.rd !== rd || e.pri !== pri || e.sec !== sec) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp rd=%02h pri=%b sec=%b, got rd=%02h pri=%b sec=%b",
                 $realtime, e.rd, e.pri, e.sec, rd, pri, sec);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 500;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic            cmd;
  logic [IO_W-1:0] io_address;
  logic [7:0]      write_data;
  logic            out_valid;
  logic            out_ready;
  logic [7:0]      read_data;
  logic            primary_enable;
  logic            secondary_enable;

  ide_reg_scoreboard sb;
  int                cycle_cnt;
  int                burst_left;
  int                counted_items;
  int                stall_left;
  int                stall_mode;

  ide_timing_config_register_file_core DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .io_address       (io_address),
    .write_data       (write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .read_data        (read_data),
    .primary_enable   (primary_enable),
    .secondary_enable (secondary_enable)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: checks at the edge, then picks next cycle's ready. Modes switch
  // between a solid-ready stretch, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_access(read_data, primary_enable, secondary_enable);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
      out_ready  <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Sender pacing: bursts of random length with idle gaps between them.
  task automatic access(input logic c, input logic [IO_W-1:0] a, input logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid   <= 1'b1;
    cmd        <= c;
    io_address <= a;
    write_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_access(c, a, d);
    // writes to undecoded ports do nothing, so they are not counted
    if (!(c == CMD_WRITE && a != PORT_UNLOCK && a != PORT_INDEX && a != PORT_DATA))
      counted_items++;
  endtask

  task automatic random_sequence();
    logic [7:0]      idx;
    logic [IO_W-1:0] a;
    int              n;
    if ($urandom_range(0, 9) < 7) begin
      idx = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 8'h3F))
                                       : 8'($urandom_range(0, 255));
      access(CMD_WRITE, PORT_INDEX, idx);
      if ($urandom_range(0, 4) == 0)
        access(CMD_WRITE, PORT_UNLOCK,
               ($urandom_range(0, 4) == 0) ? 8'($urandom) : UNLOCK_KEY);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        access(($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ, PORT_DATA, 8'($urandom));
      if ($urandom_range(0, 5) == 0)
        access(CMD_READ, PORT_UNLOCK, 8'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0:       a = PORT_INDEX;
        1:       a = 16'($urandom);
        2:       a = PORT_DATA ^ (16'h1 << $urandom_range(0, 15));
        default: a = PORT_UNLOCK ^ (16'h1 << $urandom_range(0, 15));
      endcase
      access(($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ, a, 8'($urandom));
    end
  endtask

  initial begin
    sb            = new();
    cycle_cnt     = 0;
    burst_left    = 0;
    counted_items = 0;
    stall_left    = 0;
    stall_mode    = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    cmd           = CMD_READ;
    io_address    = '0;
    write_data    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values, write-only index port, locked data write
    access(CMD_READ, PORT_UNLOCK, 8'h00);
    access(CMD_READ, PORT_INDEX, 8'h00);
    access(CMD_READ, PORT_DATA, 8'h00);
    access(CMD_WRITE, PORT_INDEX, IDX_PORT_EN);
    access(CMD_WRITE, PORT_DATA, 8'hFF);
    access(CMD_READ, PORT_DATA, 8'h00);
    // unlock, enable both channels, disable the secondary one, then enable it again
    access(CMD_WRITE, PORT_UNLOCK, UNLOCK_KEY);
    access(CMD_READ, PORT_UNLOCK, 8'hFF);
    access(CMD_WRITE, PORT_DATA, 8'hFF);
    access(CMD_READ, PORT_DATA, 8'h00);
    access(CMD_WRITE, PORT_INDEX, IDX_SEC_CTL);
    access(CMD_WRITE, PORT_DATA, 8'h40);
    access(CMD_READ, PORT_DATA, 8'h00);
    access(CMD_WRITE, PORT_DATA, 8'h00);
    // read-only and unknown indices drop writes; a masked index keeps its writable bits
    access(CMD_WRITE, PORT_INDEX, 8'h00);
    access(CMD_WRITE, PORT_DATA, 8'hAA);
    access(CMD_READ, PORT_DATA, 8'h00);
    access(CMD_WRITE, PORT_INDEX, 8'h34);
    access(CMD_WRITE, PORT_DATA, 8'h00);
    access(CMD_READ, PORT_DATA, 8'h00);
    access(CMD_WRITE, PORT_INDEX, 8'hFF);
    access(CMD_WRITE, PORT_DATA, 8'hFF);
    access(CMD_READ, PORT_DATA, 8'h00);
    access(CMD_WRITE, PORT_INDEX, 8'h09);
    access(CMD_WRITE, PORT_DATA, 8'hFF);
    access(CMD_READ, PORT_DATA, 8'h00);
    // unmapped ports
    access(CMD_READ, 16'hFFFF, 8'h00);
    access(CMD_WRITE, 16'h0000, 8'hFF);
    access(CMD_READ, 16'h01FC, 8'h00);

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) random_sequence();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### files.f
src/ide_trf_pkg.sv
src/ide_timing_config_register_file_core.sv
bench/tb_top.sv
